@@ src/http_header_framing_parser_macros.svh @@
// Assertion macros used by the header framing parser checker.
`ifndef HTTP_HEADER_FRAMING_PARSER_MACROS_SVH
`define HTTP_HEADER_FRAMING_PARSER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define HHFP_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define HHFP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/hhfp_pkg.sv @@
// Types, constants and per-byte update functions of the header framing parser.
package hhfp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int WIDE_W      = LENGTH_BITS + 4;
  localparam int OUT_LEN_W   = 32;
  localparam int NAME_POS_W  = 5;

  localparam int LEN_NAME_N = 14;
  localparam int TE_NAME_N  = 17;
  localparam logic [8*LEN_NAME_N-1:0] LEN_NAME = "content-length";
  localparam logic [8*TE_NAME_N-1:0]  TE_NAME  = "transfer-encoding";

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_XFER_ENC  = 3'd1,
    ERR_DUP_LEN   = 3'd2,
    ERR_MALFORMED = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    VP_NONE   = 2'd0,
    VP_LEAD   = 2'd1,
    VP_DIGITS = 2'd2,
    VP_TRAIL  = 2'd3
  } phase_e;

  typedef struct packed {
    logic                   cr_pending;
    logic                   line_empty;
    logic                   colon_seen;
    logic [NAME_POS_W-1:0]  name_pos;
    logic [1:0]             match;
    phase_e                 phase;
    logic [LENGTH_BITS-1:0] acc;
    logic                   length_seen;
    err_e                   first_error;
    logic [LENGTH_BITS-1:0] stored;
  } parse_state_t;

  typedef struct packed {
    logic                 accepted;
    err_e                 err_code;
    logic [OUT_LEN_W-1:0] length;
  } hhfp_result_t;

  function automatic parse_state_t line_clear(parse_state_t s);
    parse_state_t n;
    n            = s;
    n.colon_seen = 1'b0;
    n.name_pos   = '0;
    n.match      = 2'b11;
    n.phase      = VP_NONE;
    n.acc        = '0;
    n.line_empty = 1'b1;
    return n;
  endfunction

  function automatic parse_state_t init_state();
    parse_state_t n;
    n             = '0;
    n.cr_pending  = 1'b0;
    n.length_seen = 1'b0;
    n.first_error = ERR_NONE;
    n.stored      = '0;
    return line_clear(n);
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) r = c + CASE_OFS;
    return r;
  endfunction

  function automatic logic [7:0] len_char(logic [NAME_POS_W-1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < NAME_POS_W'(LEN_NAME_N)) c = LEN_NAME[8*(LEN_NAME_N-1-int'(pos)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] te_char(logic [NAME_POS_W-1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < NAME_POS_W'(TE_NAME_N)) c = TE_NAME[8*(TE_NAME_N-1-int'(pos)) +: 8];
    return c;
  endfunction

  function automatic parse_state_t set_error(parse_state_t s, err_e code);
    parse_state_t n;
    n = s;
    if (s.first_error == ERR_NONE) n.first_error = code;
    n.phase = VP_NONE;
    return n;
  endfunction

  function automatic parse_state_t add_digit(parse_state_t s, logic [7:0] b);
    parse_state_t      n;
    logic [WIDE_W-1:0] sum;
    n   = s;
    sum = WIDE_W'({s.acc, 3'b000}) + WIDE_W'({s.acc, 1'b0}) + WIDE_W'(b[3:0]);
    if (sum[WIDE_W-1:LENGTH_BITS] != '0) begin
      n = set_error(s, ERR_OVERFLOW);
    end else begin
      n.acc   = sum[LENGTH_BITS-1:0];
      n.phase = VP_DIGITS;
    end
    return n;
  endfunction

  function automatic parse_state_t content_step(parse_state_t s, logic [7:0] b);
    parse_state_t n;
    logic         ws;
    logic         dig;
    logic         is_len;
    logic         is_te;
    n            = s;
    ws           = (b == CH_SPACE) || (b == CH_TAB);
    dig          = (b >= CH_ZERO) && (b <= CH_NINE);
    is_len       = s.match[0] && (s.name_pos == NAME_POS_W'(LEN_NAME_N));
    is_te        = s.match[1] && (s.name_pos == NAME_POS_W'(TE_NAME_N));
    n.line_empty = 1'b0;
    if (s.first_error == ERR_NONE) begin
      if (!s.colon_seen) begin
        if (b == CH_COLON) begin
          n.colon_seen = 1'b1;
          if (is_te) begin
            n = set_error(n, ERR_XFER_ENC);
          end else if (is_len) begin
            if (s.length_seen) begin
              n = set_error(n, ERR_DUP_LEN);
            end else begin
              n.length_seen = 1'b1;
              n.phase       = VP_LEAD;
              n.acc         = '0;
            end
          end
        end else begin
          if (s.name_pos >= NAME_POS_W'(LEN_NAME_N) || fold(b) != len_char(s.name_pos))
            n.match[0] = 1'b0;
          if (s.name_pos >= NAME_POS_W'(TE_NAME_N) || fold(b) != te_char(s.name_pos))
            n.match[1] = 1'b0;
          if (s.name_pos != '1) n.name_pos = s.name_pos + 1'b1;
        end
      end else begin
        case (s.phase)
          VP_LEAD: begin
            if (dig) n = add_digit(n, b);
            else if (!ws) n = set_error(n, ERR_MALFORMED);
          end
          VP_DIGITS: begin
            if (dig) n = add_digit(n, b);
            else if (ws) n.phase = VP_TRAIL;
            else n = set_error(n, ERR_MALFORMED);
          end
          VP_TRAIL: begin
            if (!ws) n = set_error(n, ERR_MALFORMED);
          end
          default: begin
          end
        endcase
      end
    end
    return n;
  endfunction

  function automatic parse_state_t line_end(parse_state_t s);
    parse_state_t n;
    n = s;
    if (s.first_error == ERR_NONE) begin
      if (s.phase == VP_LEAD) n = set_error(n, ERR_MALFORMED);
      else if (s.phase == VP_DIGITS || s.phase == VP_TRAIL) n.stored = s.acc;
    end
    return line_clear(n);
  endfunction

endpackage

@@ src/hhfp_engine.sv @@
// Parse state register and per-byte next-state logic of the header framing parser.
module hhfp_engine import hhfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output logic         emit_o,
  output hhfp_result_t result_o
);

  parse_state_t state_q;
  parse_state_t state_d;
  parse_state_t upd;
  logic         emit;

  always_comb begin
    upd  = state_q;
    emit = 1'b0;
    if (state_q.cr_pending) begin
      upd.cr_pending = 1'b0;
      if (byte_i == CH_LF) begin
        if (state_q.line_empty) begin
          emit = 1'b1;
          upd  = init_state();
        end else begin
          upd = line_end(upd);
        end
      end else begin
        upd = content_step(upd, CH_CR);
      end
    end
    if (!(state_q.cr_pending && byte_i == CH_LF)) begin
      if (byte_i == CH_CR) upd.cr_pending = 1'b1;
      else upd = content_step(upd, byte_i);
    end
    state_d = step_i ? upd : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= init_state();
    end else begin
      state_q <= state_d;
    end
  end

  assign emit_o            = emit;
  assign result_o.accepted = (state_q.first_error == ERR_NONE);
  assign result_o.err_code = state_q.first_error;
  assign result_o.length   = (state_q.first_error == ERR_NONE) ?
                             OUT_LEN_W'(state_q.stored) : '0;

endmodule

@@ src/http_header_framing_parser.sv @@
// Top level of the HTTP header framing parser.
// Takes one header byte per transaction, starting at the first header line, and
// gives one result transaction on the terminating empty line: accepted, the first
// error code and the Content-Length value (0 when absent or rejected). A byte is
// taken every cycle unless input stalls; it is held in the input register, is
// folded into the parse state when it advances, and the result it completes, if
// any, is written to the output register in the same cycle. The output register
// lets new bytes flow while a result waits; input stalls only when a result
// must be issued and the previous one is still held by a stalled receiver.
module http_header_framing_parser import hhfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  err_code_o,
  output logic [31:0] body_len_o
);

  logic         in_valid_q;
  logic         in_valid_d;
  logic [7:0]   byte_q;
  logic         out_valid_q;
  logic         out_valid_d;
  hhfp_result_t result_q;
  hhfp_result_t result;
  logic         emit;
  logic         out_free;
  logic         advance;
  logic         in_take;

  hhfp_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .emit_o   (emit),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) byte_q <= data_byte_i;
    if (advance && emit) result_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = result_q.accepted;
  assign err_code_o  = result_q.err_code;
  assign body_len_o  = result_q.length;

endmodule

@@ src/hhfp_checker.sv @@
// Port-level assertions for the header framing parser and their bind.
`include "http_header_framing_parser_macros.svh"

module hhfp_checker import hhfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        accepted_o,
  input logic [2:0]  err_code_o,
  input logic [31:0] body_len_o
);

  logic                 held;
  logic                 rejected;
  logic                 no_err;
  logic [OUT_LEN_W+3:0] res_bits;

  assign held     = out_valid_o && out_stall_i;
  assign rejected = out_valid_o && !accepted_o;
  assign no_err   = (err_code_o == ERR_NONE);
  assign res_bits = {accepted_o, err_code_o, body_len_o};

  `HHFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(res_bits), "moved")
  `HHFP_ASSERT_NOW(a_accept_code, clk_i, rst_ni, out_valid_o, accepted_o == no_err, "bad flag")
  `HHFP_ASSERT_NOW(a_reject_len, clk_i, rst_ni, rejected, body_len_o == '0, "length on reject")
  `HHFP_ASSERT_NOW(a_code_range, clk_i, rst_ni, out_valid_o, err_code_o <= ERR_OVERFLOW, "bad code")

endmodule

bind http_header_framing_parser hhfp_checker u_hhfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .accepted_o  (accepted_o),
  .err_code_o  (err_code_o),
  .body_len_o  (body_len_o)
);

@@ bench/tb_http_header_framing_parser.sv @@
// Self-checking testbench for the HTTP header framing parser, one header byte per transaction.
module tb_http_header_framing_parser;
  import hhfp_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RESET_CYCLES   = 9;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 40;
  localparam int RANDOM_HEADERS = 2;
  localparam logic [63:0] LENGTH_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam string EOL = "\015\012";
  localparam string LONE_CR = "\015";

  typedef enum int {RX_FREE, RX_PATCHY, RX_CHOKED} rx_mode_e;
  typedef enum int {LN_LENGTH, LN_XFER, LN_OTHER, LN_NOISE} line_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accepted_o;
  logic [2:0]  err_code_o;
  logic [31:0] body_len_o;

  http_header_framing_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o),
    .err_code_o  (err_code_o),
    .body_len_o  (body_len_o)
  );

  always #2 clk_i = ~clk_i;

  string                  len_word = "content-length";
  string                  te_word  = "transfer-encoding";
  logic                   cr_held;
  logic                   blank_line;
  logic                   past_colon;
  logic                   have_length;
  logic [NAME_POS_W-1:0]  name_idx;
  logic [1:0]             cand;
  phase_e                 val_phase;
  logic [LENGTH_BITS-1:0] acc_val;
  logic [LENGTH_BITS-1:0] length_kept;
  err_e                   err_first;

  hhfp_result_t verdicts_due[$];
  logic [7:0]   bytes_pending[$];

  int       errors = 0;
  int       bytes_taken = 0;
  int       headers_seen = 0;
  int       accepted_seen = 0;
  int       rejects_by_code[8] = '{default: 0};
  int       cycle_count = 0;
  int       pressure_at = 32'h7FFF_FFFF;
  int       hold_left = 0;
  int       mode_left = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  bit       in_taken = 1'b0;
  bit       hold_done = 1'b0;
  rx_mode_e rx_mode = RX_FREE;

  task automatic clear_line();
    past_colon = 1'b0;
    name_idx   = '0;
    cand       = 2'b11;
    val_phase  = VP_NONE;
    acc_val    = '0;
    blank_line = 1'b1;
  endtask

  task automatic clear_header();
    cr_held     = 1'b0;
    have_length = 1'b0;
    err_first   = ERR_NONE;
    length_kept = '0;
    clear_line();
  endtask

  task automatic note_error(input err_e code);
    if (err_first == ERR_NONE) err_first = code;
    val_phase = VP_NONE;
  endtask

  task automatic take_digit(input logic [7:0] b);
    logic [63:0] grown;
    grown = 64'(acc_val) * 64'd10 + 64'(b - CH_ZERO);
    if (grown > LENGTH_MAX) begin
      note_error(ERR_OVERFLOW);
    end else begin
      acc_val   = grown[LENGTH_BITS-1:0];
      val_phase = VP_DIGITS;
    end
  endtask

  task automatic fold_content(input logic [7:0] b);
    logic [7:0] lc;
    logic       ws;
    logic       dig;
    lc  = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
    ws  = (b == CH_SPACE) || (b == CH_TAB);
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    blank_line = 1'b0;
    if (err_first != ERR_NONE) return;
    if (!past_colon) begin
      if (b == CH_COLON) begin
        past_colon = 1'b1;
        if (cand[1] && name_idx == TE_NAME_N) begin
          note_error(ERR_XFER_ENC);
        end else if (cand[0] && name_idx == LEN_NAME_N) begin
          if (have_length) begin
            note_error(ERR_DUP_LEN);
          end else begin
            have_length = 1'b1;
            val_phase   = VP_LEAD;
            acc_val     = '0;
          end
        end
      end else begin
        if (name_idx >= LEN_NAME_N || lc != len_word[name_idx]) cand[0] = 1'b0;
        if (name_idx >= TE_NAME_N || lc != te_word[name_idx]) cand[1] = 1'b0;
        if (name_idx != '1) name_idx = name_idx + 1'b1;
      end
    end else begin
      case (val_phase)
        VP_LEAD: begin
          if (dig) take_digit(b);
          else if (!ws) note_error(ERR_MALFORMED);
        end
        VP_DIGITS: begin
          if (dig) take_digit(b);
          else if (ws) val_phase = VP_TRAIL;
          else note_error(ERR_MALFORMED);
        end
        VP_TRAIL: begin
          if (!ws) note_error(ERR_MALFORMED);
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    hhfp_result_t verdict;
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == CH_LF) begin
        if (blank_line) begin
          verdict.accepted = (err_first == ERR_NONE);
          verdict.err_code = err_first;
          verdict.length   = verdict.accepted ? OUT_LEN_W'(length_kept) : '0;
          verdicts_due.push_back(verdict);
          clear_header();
        end else begin
          if (err_first == ERR_NONE) begin
            if (val_phase == VP_LEAD) note_error(ERR_MALFORMED);
            else if (val_phase == VP_DIGITS || val_phase == VP_TRAIL) length_kept = acc_val;
          end
          clear_line();
        end
        return;
      end
      fold_content(CH_CR);
    end
    if (b == CH_CR) cr_held = 1'b1;
    else fold_content(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) bytes_pending.push_back(s[i]);
  endtask

  task automatic push_random(input int count);
    logic [7:0] b;
    repeat (count) begin
      case ($urandom_range(0, 11))
        0:       b = CH_CR;
        1:       b = CH_LF;
        2:       b = CH_COLON;
        default: b = 8'($urandom_range(0, 255));
      endcase
      bytes_pending.push_back(b);
    end
  endtask

  task automatic push_name(input int count);
    repeat (count) bytes_pending.push_back(8'($urandom_range(8'h41, 8'h7A)));
  endtask

  function automatic string blanks();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) != 0) s = {s, " "};
      else s = {s, "\t"};
    end
    return s;
  endfunction

  function automatic string spell_name(input string word);
    string      s;
    logic [7:0] c;
    s = word;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) != 0) s[i] = c - CASE_OFS;
    end
    if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(33, 126));
    if ($urandom_range(0, 9) == 0) s = {s, " "};
    return s;
  endfunction

  function automatic string length_value();
    string       s;
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $sformatf("%0d", $urandom_range(0, 99999));
      4:          s = $sformatf("00%0d", $urandom_range(0, 999));
      5, 6:       s = $sformatf("%0d", $urandom);
      7:          s = $sformatf("%0d", LENGTH_MAX);
      8: begin
        v = {32'($urandom_range(1, 65535)), 32'($urandom)};
        s = $sformatf("%0d", v);
      end
      default: begin
        s = $sformatf("%0d%c%0d", $urandom_range(0, 99), 8'($urandom_range(33, 47)),
                      $urandom_range(0, 9));
      end
    endcase
    return s;
  endfunction

  task automatic add_random_header();
    int         pick;
    line_kind_e kind;
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? LN_LENGTH : (pick == 4) ? LN_XFER : (pick < 9) ? LN_OTHER : LN_NOISE;
      case (kind)
        LN_LENGTH: push_text({spell_name(len_word), ":", blanks(), length_value(), blanks(), EOL});
        LN_XFER:   push_text({spell_name(te_word), ":", blanks(), "chunked", EOL});
        LN_OTHER: begin
          push_name(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12));
          push_text({":", blanks()});
          push_random($urandom_range(0, 8));
          push_text(EOL);
        end
        default: begin
          push_random($urandom_range(1, 10));
          push_text(EOL);
        end
      endcase
    end
    push_text(EOL);
  endtask

  always @(posedge clk_i) begin : watch
    hhfp_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        headers_seen++;
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: accepted %0b code %0d length %0d", $time,
                   accepted_o, err_code_o, body_len_o);
        end else begin
          want = verdicts_due.pop_front();
          if (want.accepted) accepted_seen++;
          else rejects_by_code[want.err_code]++;
          if (accepted_o !== want.accepted) begin
            errors++;
            $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, accepted_o);
          end
          if (err_code_o !== want.err_code) begin
            errors++;
            $display("%0t: err_code expected %0d actual %0d", $time, want.err_code,
                     err_code_o);
          end
          if (body_len_o !== want.length) begin
            errors++;
            $display("%0t: body_len expected %0d actual %0d", $time, want.length,
                     body_len_o);
          end
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        bytes_taken++;
        absorb_byte(data_byte_i);
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  always @(negedge clk_i) begin : feed
    logic       offer;
    logic [7:0] next_byte;
    offer     = in_valid_i;
    next_byte = data_byte_i;
    if (in_valid_i && in_taken) begin
      void'(bytes_pending.pop_front());
      offer = 1'b0;
    end
    if (!offer && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (bytes_pending.size() > 0) begin
        offer     = 1'b1;
        next_byte = bytes_pending[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid_i  <= offer;
    data_byte_i <= next_byte;
  end

  always @(negedge clk_i) begin : drain
    logic hold;
    if (hold_left > 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (!hold_done && bytes_taken >= pressure_at) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold      = 1'b1;
    end else begin
      if (mode_left > 0) begin
        mode_left--;
      end else begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 60);
      end
      case (rx_mode)
        RX_FREE:   hold = 1'b0;
        RX_PATCHY: hold = $urandom_range(0, 1);
        default:   hold = ($urandom_range(0, 4) != 0);
      endcase
    end
    out_stall_i <= hold;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int random_start;
    int random_headers;
    clear_header();

    push_text(EOL);
    push_text({"Content-Length: 42", EOL, "Host: example", EOL, EOL});
    push_text({"cONTENT-lENGTH:\t 4294967295 \t", EOL, EOL});
    push_text({"Content-Length:0", EOL, EOL});
    push_text({"content-length: 4294967296", EOL, EOL});
    push_text({"Content-Length: 99999999999999999999", EOL, EOL});
    push_text({"TRANSFER-ENCODING:chunked", EOL, "Content-Length: x", EOL, EOL});
    push_text({"Content-Length: 1", EOL, "X-A: b", EOL, "content-length: 1", EOL, EOL});
    push_text({"Content-Length: 1 2", EOL, EOL});
    push_text({"Content-Length: \t ", EOL, EOL});
    push_text({"Content-Length: 5", LONE_CR, EOL, EOL});
    push_text({"Host: a", LONE_CR, "b", EOL, "Content-Length: 9", EOL, EOL});
    push_text({"X-Y: z\n", EOL, EOL});
    push_text({"Host: a:b:c", EOL, "Content-Length: 3", EOL, EOL});
    push_text({"Content-Length : 5", EOL, "Transfer-Encodin: x", EOL});
    push_text({"Content-Lengthh: 6", EOL, EOL});
    push_text({"aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa: 1", EOL, "Content-Length: 007", EOL, EOL});
    push_text("Content-Lengt");
    bytes_pending.push_back(8'hFF);
    push_text(": 8\n");
    bytes_pending.push_back(8'h00);
    bytes_pending.push_back(8'h80);
    push_text(": ");
    bytes_pending.push_back(8'h7F);
    push_text({EOL, EOL});
    push_text({LONE_CR, EOL, EOL});

    pressure_at = bytes_pending.size();
    repeat (12) push_text(EOL);

    random_start   = bytes_pending.size();
    random_headers = 0;
    while (bytes_pending.size() - random_start < RANDOM_BYTES ||
           random_headers < RANDOM_HEADERS) begin
      add_random_header();
      random_headers++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_pending.size() != 0 || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d header bytes over %0d header blocks, %0d accepted", bytes_taken,
             headers_seen, accepted_seen);
    $display("rejected: transfer-encoding %0d, duplicate length %0d, malformed %0d, overflow %0d",
             rejects_by_code[ERR_XFER_ENC], rejects_by_code[ERR_DUP_LEN],
             rejects_by_code[ERR_MALFORMED], rejects_by_code[ERR_OVERFLOW]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/hhfp_pkg.sv
src/hhfp_engine.sv
src/http_header_framing_parser.sv
src/hhfp_checker.sv
bench/tb_http_header_framing_parser.sv
